// File: rtl/ovt_pkg.sv
// Shared types and constants for the open-loop vector drive with current trip.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package ovt_pkg;

   localparam int CUR_W     = 18;   // signed phase current fields
   localparam int MAG_W     = 19;   // internal magnitude (reaches 262144)
   localparam int SUM_W     = 20;   // signed sums and differences of currents
   localparam int FIELD_W   = 16;   // frequency, amplitude, angle
   localparam int LIMIT_W   = 17;   // current limit register
   localparam int PHASE_W   = 32;   // phase accumulator
   localparam int RUN_W     = 16;   // over-limit run counter
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 17;

   localparam logic [17:0]        STEP_PER_HZ  = 18'd134217;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 17'd10000;
   localparam logic [CUR_W-1:0]   MAG_FIELD_MAX = 18'h3FFFF;

   typedef enum logic [1:0] {
      ACT_SAMPLE = 2'd0,
      ACT_START  = 2'd1,
      ACT_STOP   = 2'd2
   } action_type;

   localparam logic [CSR_IDX_W-1:0] CSR_FREQUENCY     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_LIMIT = 2'd2;

endpackage

`default_nettype wire

// File: rtl/ovt_req_if.sv
// Input channel: sample / start / stop beats with two phase currents.
// Depends on ovt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ovt_req_if import ovt_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               action;
   logic signed [CUR_W-1:0]  phase_a_current;
   logic signed [CUR_W-1:0]  phase_b_current;

   modport source (output valid, action, phase_a_current, phase_b_current, input ready);
   modport sink   (input valid, action, phase_a_current, phase_b_current, output ready);
endinterface

`default_nettype wire

// File: rtl/ovt_rsp_if.sv
// Result channel: one beat per accepted input beat.
// Depends on ovt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ovt_rsp_if import ovt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               drive_active;
   logic [FIELD_W-1:0] electrical_angle;
   logic [FIELD_W-1:0] applied_amplitude;
   logic               gates_off;
   logic               aborted;
   logic [CUR_W-1:0]   largest_current;
   logic [CUR_W-1:0]   peak_current;
   logic [CUR_W-1:0]   average_current;
   logic [CUR_W-1:0]   abort_current;

   modport source (output valid, drive_active, electrical_angle, applied_amplitude,
                   gates_off, aborted, largest_current, peak_current,
                   average_current, abort_current, input ready);
   modport sink   (input valid, drive_active, electrical_angle, applied_amplitude,
                   gates_off, aborted, largest_current, peak_current,
                   average_current, abort_current, output ready);
endinterface

`default_nettype wire

// File: rtl/ovt_csr_if.sv
// Register write channel: index and data.
// Depends on ovt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ovt_csr_if import ovt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [CSR_DAT_W-1:0] write_data;

   modport source (output valid, reg_index, write_data, input ready);
   modport sink   (input valid, reg_index, write_data, output ready);
endinterface

`default_nettype wire

// File: rtl/openloop_vector_with_overcurrent_trip.sv
// Top level: open-loop rotating-vector drive with overcurrent supervisor.
// Depends on ovt_pkg, ovt_req_if, ovt_rsp_if, ovt_csr_if.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Beat contents
// -------  ---  ---------------------------------------------------------
// req_if   in   action (sample/start/stop), phase A and B current (mA)
// rsp_if   out  drive flag, angle, amplitude, gate-off pulse, abort flag,
//               largest / peak / average / abort-latched current (mA)
// csr_if   in   register index, write data (frequency, amplitude, limit)
//
// One beat per clock sustained while rsp_if.ready stays high. A beat
// is held in the input register, where the current stats, trip check
// and phase advance are worked out, then lands in the result register.
// The result register and input register form a two-entry pipe, so a new
// beat is taken while a finished result waits on rsp_if.ready.
// Reset (synchronous) clears drive state, stats and both valids; the
// limit register comes up at 10000 mA. csr_if is always ready.

module openloop_vector_with_overcurrent_trip import ovt_pkg::*; #(
   parameter int unsigned FILTER_SHIFT = 8,
   parameter int unsigned TRIP_RUN     = 4,
   parameter int unsigned FREQ_CEILING = 1000,
   parameter int unsigned AMPL_CEILING = 950
) (
   input  wire        clock,
   input  wire        reset,
   ovt_req_if.sink    req_if,
   ovt_rsp_if.source  rsp_if,
   ovt_csr_if.sink    csr_if
);

   localparam logic [FIELD_W-1:0] FREQ_CEIL_C = FIELD_W'(FREQ_CEILING);
   localparam logic [FIELD_W-1:0] AMPL_CEIL_C = FIELD_W'(AMPL_CEILING);
   localparam logic [RUN_W-1:0]   TRIP_RUN_C  = RUN_W'(TRIP_RUN);
   localparam logic [RUN_W-1:0]   RUN_MAX     = {RUN_W{1'b1}};

   function automatic logic [MAG_W-1:0] mag(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] neg;
      neg = -v;
      return v[SUM_W-1] ? neg[MAG_W-1:0] : v[MAG_W-1:0];
   endfunction

   function automatic logic [CUR_W-1:0] sat18(input logic [MAG_W-1:0] v);
      return v[MAG_W-1] ? MAG_FIELD_MAX : v[CUR_W-1:0];
   endfunction

   // ---------------- configuration registers ----------------
   // Frequency is stored already clamped and scaled to a phase step.
   logic [PHASE_W-1:0] phase_step_ff;
   logic [FIELD_W-1:0] amplitude_ff;
   logic [LIMIT_W-1:0] limit_ff;

   logic [FIELD_W-1:0] csr_freq;
   logic [FIELD_W-1:0] csr_ampl;
   logic [FIELD_W+17:0] step_prod;
   logic               csr_write;

   assign csr_if.ready = 1'b1;
   assign csr_write    = csr_if.valid;
   assign csr_freq     = (csr_if.write_data[FIELD_W-1:0] > FREQ_CEIL_C) ?
                         FREQ_CEIL_C : csr_if.write_data[FIELD_W-1:0];
   assign csr_ampl     = (csr_if.write_data[FIELD_W-1:0] > AMPL_CEIL_C) ?
                         AMPL_CEIL_C : csr_if.write_data[FIELD_W-1:0];
   assign step_prod    = csr_freq * STEP_PER_HZ;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= '0;
         amplitude_ff  <= '0;
         limit_ff      <= LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_if.reg_index)
            CSR_FREQUENCY:     phase_step_ff <= step_prod[PHASE_W-1:0];
            CSR_AMPLITUDE:     amplitude_ff  <= csr_ampl;
            CSR_CURRENT_LIMIT: limit_ff      <= csr_if.write_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- input register ----------------
   logic                    in_valid_ff;
   logic [1:0]              in_action_ff;
   logic signed [CUR_W-1:0] in_a_ff;
   logic signed [CUR_W-1:0] in_b_ff;
   logic                    rsp_valid_ff;
   logic                    advance;

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_action_ff <= req_if.action;
         in_a_ff      <= req_if.phase_a_current;
         in_b_ff      <= req_if.phase_b_current;
      end
   end

   // ---------------- drive state ----------------
   logic [PHASE_W-1:0] accum_ff,   accum_in;
   logic               run_ff,     run_in;
   logic               abort_ff,   abort_in;
   logic [MAG_W-1:0]   abort_lvl_ff, abort_lvl_in;
   logic [MAG_W-1:0]   peak_ff,    peak_in;
   logic [MAG_W-1:0]   mean_ff,    mean_in;
   logic [RUN_W-1:0]   count_ff,   count_in;

   // sample datapath
   logic signed [SUM_W-1:0] a_ext, b_ext, c_ext;
   logic [MAG_W-1:0]        mag_a, mag_b, mag_c, mag_ab, largest;
   logic signed [SUM_W-1:0] diff, mean_step, mean_sum;
   logic                    over_limit, trip;
   logic [RUN_W-1:0]        count_inc;
   logic                    active, gates;
   logic [MAG_W-1:0]        largest_out;

   assign a_ext  = SUM_W'(in_a_ff);
   assign b_ext  = SUM_W'(in_b_ff);
   assign c_ext  = -(a_ext + b_ext);
   assign mag_a  = mag(a_ext);
   assign mag_b  = mag(b_ext);
   assign mag_c  = mag(c_ext);
   assign mag_ab = (mag_b > mag_a) ? mag_b : mag_a;
   assign largest = (mag_c > mag_ab) ? mag_c : mag_ab;

   // EMA: arithmetic shift floors toward minus infinity
   assign diff      = $signed({1'b0, largest}) - $signed({1'b0, mean_ff});
   assign mean_step = diff >>> FILTER_SHIFT;
   assign mean_sum  = $signed({1'b0, mean_ff}) + mean_step;

   assign over_limit = (limit_ff != '0) && (largest > {2'b00, limit_ff});
   assign count_inc  = (count_ff == RUN_MAX) ? count_ff : count_ff + 1'b1;
   assign trip       = over_limit && (count_inc >= TRIP_RUN_C);

   always_comb begin
      accum_in     = accum_ff;
      run_in       = run_ff;
      abort_in     = abort_ff;
      abort_lvl_in = abort_lvl_ff;
      peak_in      = peak_ff;
      mean_in      = mean_ff;
      count_in     = count_ff;
      active       = 1'b0;
      gates        = 1'b0;
      largest_out  = '0;
      case (in_action_ff)
         ACT_START: begin
            abort_in     = 1'b0;
            abort_lvl_in = '0;
            peak_in      = '0;
            mean_in      = '0;
            count_in     = '0;
            run_in       = 1'b1;
         end
         ACT_STOP: begin
            run_in = 1'b0;
            gates  = 1'b1;
         end
         ACT_SAMPLE: begin
            if (run_ff) begin
               largest_out = largest;
               peak_in     = (largest > peak_ff) ? largest : peak_ff;
               mean_in     = mean_sum[MAG_W-1:0];
               if (limit_ff != '0) begin
                  count_in = over_limit ? count_inc : '0;
               end
               if (trip) begin
                  run_in       = 1'b0;
                  abort_in     = 1'b1;
                  abort_lvl_in = largest;
                  gates        = 1'b1;
               end else begin
                  accum_in = accum_ff + phase_step_ff;
                  active   = 1'b1;
               end
            end
         end
         default: ;   // unused code: no effect
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff     <= '0;
         run_ff       <= 1'b0;
         abort_ff     <= 1'b0;
         abort_lvl_ff <= '0;
         peak_ff      <= '0;
         mean_ff      <= '0;
         count_ff     <= '0;
      end else begin
         if (advance) begin
            accum_ff     <= accum_in;
            run_ff       <= run_in;
            abort_ff     <= abort_in;
            abort_lvl_ff <= abort_lvl_in;
            peak_ff      <= peak_in;
            mean_ff      <= mean_in;
            count_ff     <= count_in;
         end
         // limit write restarts the over-limit run (user writes it only while idle; unchecked)
         if (csr_write && csr_if.reg_index == CSR_CURRENT_LIMIT) begin
            count_ff <= '0;
         end
      end
   end

   // ---------------- result register ----------------
   logic               rsp_active_ff;
   logic [FIELD_W-1:0] rsp_angle_ff;
   logic [FIELD_W-1:0] rsp_amp_ff;
   logic               rsp_gates_ff;
   logic               rsp_aborted_ff;
   logic [CUR_W-1:0]   rsp_largest_ff;
   logic [CUR_W-1:0]   rsp_peak_ff;
   logic [CUR_W-1:0]   rsp_mean_ff;
   logic [CUR_W-1:0]   rsp_abort_lvl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_active_ff    <= active;
         rsp_angle_ff     <= accum_in[PHASE_W-1 -: FIELD_W];
         rsp_amp_ff       <= amplitude_ff;
         rsp_gates_ff     <= gates;
         rsp_aborted_ff   <= abort_in;
         rsp_largest_ff   <= sat18(largest_out);
         rsp_peak_ff      <= sat18(peak_in);
         rsp_mean_ff      <= sat18(mean_in);
         rsp_abort_lvl_ff <= sat18(abort_lvl_in);
      end
   end

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.drive_active      = rsp_active_ff;
   assign rsp_if.electrical_angle  = rsp_angle_ff;
   assign rsp_if.applied_amplitude = rsp_amp_ff;
   assign rsp_if.gates_off         = rsp_gates_ff;
   assign rsp_if.aborted           = rsp_aborted_ff;
   assign rsp_if.largest_current   = rsp_largest_ff;
   assign rsp_if.peak_current      = rsp_peak_ff;
   assign rsp_if.average_current   = rsp_mean_ff;
   assign rsp_if.abort_current     = rsp_abort_lvl_ff;

endmodule

`default_nettype wire

// File: rtl/ovt_checker.sv
// Port-level checks on the result channel of the vector drive.
// Depends on ovt_pkg; bound to openloop_vector_with_overcurrent_trip.
`timescale 1ns / 1ps
`default_nettype none

module ovt_checker import ovt_pkg::*; (
   input wire               clock,
   input wire               reset,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input wire               rsp_drive_active,
   input wire [FIELD_W-1:0] rsp_electrical_angle,
   input wire               rsp_gates_off,
   input wire               rsp_aborted,
   input wire [CUR_W-1:0]   rsp_largest_current,
   input wire [CUR_W-1:0]   rsp_peak_current,
   input wire [CUR_W-1:0]   rsp_abort_current
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_electrical_angle) && $stable(rsp_gates_off))
      else $error("result beat changed while stalled");

   // a new vector and a gate shutdown never go out together
   a_drive_xor_gates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_drive_active && rsp_gates_off))
      else $error("drive_active with gates_off");

   // driving implies no abort since the last start
   a_drive_not_aborted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive_active |-> !rsp_aborted)
      else $error("drive_active while aborted");

   a_peak_covers: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_largest_current <= rsp_peak_current)
      else $error("largest current above peak");

   // a trip needs a magnitude above a nonzero limit
   a_abort_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_aborted |-> rsp_abort_current != '0)
      else $error("aborted with zero latched current");

endmodule

bind openloop_vector_with_overcurrent_trip ovt_checker u_ovt_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_if.valid),
   .rsp_ready            (rsp_if.ready),
   .rsp_drive_active     (rsp_if.drive_active),
   .rsp_electrical_angle (rsp_if.electrical_angle),
   .rsp_gates_off        (rsp_if.gates_off),
   .rsp_aborted          (rsp_if.aborted),
   .rsp_largest_current  (rsp_if.largest_current),
   .rsp_peak_current     (rsp_if.peak_current),
   .rsp_abort_current    (rsp_if.abort_current)
);

`default_nettype wire
